/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define DBFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DBFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dbfs_pkg.sv */
`default_nettype none
package dbfs_pkg;

    localparam int SAMPLES_PER_BUFFER = 16384;
    localparam int TABLE_DEPTH        = 128;

    localparam int OFFSET_W = $clog2(SAMPLES_PER_BUFFER);
    localparam int KEY_W    = 14;
    localparam int POS_W    = 32;
    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = IDX_W + 1;
    localparam int ADDR_W   = IDX_W + 1;
    localparam int OUT_IDX_W = 7;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] entry_index;
        logic                 below_all;
        logic                 bank_used;
    } dbfs_result_t;

endpackage
`default_nettype wire

/* src/dbfs_key_ram.sv */
`default_nettype none
module dbfs_key_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 14
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/dbfs_search_ctrl.sv */
`default_nettype none
module dbfs_search_ctrl
    import dbfs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     idle,
    input  wire logic [1:0]          kind,
    input  wire logic                bank,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [POS_W-1:0]    play_position,
    output logic                     mem_we,
    output logic [ADDR_W-1:0]        mem_waddr,
    output logic [KEY_W-1:0]         mem_wdata,
    output logic [ADDR_W-1:0]        mem_raddr,
    input  wire logic [KEY_W-1:0]    mem_rdata,
    output logic                     res_valid,
    output dbfs_result_t             res,
    input  wire logic                res_take
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg [2];
    logic [CNT_W-1:0]    cnt_next [2];
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic signed [CNT_W:0] hi_reg, hi_next;
    logic [IDX_W-1:0]    mid_reg, mid_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                sel_reg, sel_next;
    dbfs_result_t        res_reg, res_next;

    logic [CNT_W:0]      mid_sum;
    logic [IDX_W-1:0]    mid_calc;
    logic [KEY_W-1:0]    key_cmp;
    logic [OFFSET_W-1:0] pos_offset;
    logic                pos_sel;
    logic [CNT_W-1:0]    cnt_sel;

    assign pos_offset = play_position[OFFSET_W-1:0];
    assign pos_sel    = play_position[OFFSET_W];
    assign cnt_sel    = pos_sel ? cnt_reg[1] : cnt_reg[0];
    // Both bounds are non-negative while a probe is issued, so the halved sum is the midpoint.
    assign mid_sum    = {1'b0, lo_reg} + hi_reg[CNT_W:0];
    assign mid_calc   = mid_sum[IDX_W:1];
    assign key_cmp    = mem_rdata;

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign mem_raddr = {sel_reg, mid_calc};
    assign mem_wdata = key;
    assign mem_waddr = {bank, (bank ? cnt_reg[1][IDX_W-1:0] : cnt_reg[0][IDX_W-1:0])};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next[0] = cnt_reg[0];
        cnt_next[1] = cnt_reg[1];
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        offset_next = offset_reg;
        sel_next    = sel_reg;
        res_next    = res_reg;
        mem_we      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (kind)
                        KIND_CLEAR:
                        begin
                            cnt_next[bank] = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (cnt_reg[bank] < CNT_W'(TABLE_DEPTH))
                            begin
                                mem_we         = 1'b1;
                                cnt_next[bank] = cnt_reg[bank] + 1'b1;
                            end
                        end
                        KIND_QUERY:
                        begin
                            offset_next = pos_offset;
                            sel_next    = pos_sel;
                            lo_next     = '0;
                            hi_next     = $signed({1'b0, cnt_sel}) - $signed((CNT_W+1)'(1));
                            state_next  = S_CHECK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if ($signed({1'b0, lo_reg}) <= hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
                else
                begin
                    res_next.below_all   = hi_reg[CNT_W];
                    res_next.entry_index = hi_reg[CNT_W] ? '0 : OUT_IDX_W'(hi_reg[IDX_W-1:0]);
                    res_next.bank_used   = sel_reg;
                    state_next           = S_DONE;
                end
            end
            S_CMP:
            begin
                if (key_cmp == offset_reg)
                begin
                    res_next.below_all   = 1'b0;
                    res_next.entry_index = OUT_IDX_W'(mid_reg);
                    res_next.bank_used   = sel_reg;
                    state_next           = S_DONE;
                end
                else
                begin
                    if (key_cmp < offset_reg)
                    begin
                        lo_next = {1'b0, mid_reg} + 1'b1;
                    end
                    else
                    begin
                        hi_next = $signed({2'b00, mid_reg}) - $signed((CNT_W+1)'(1));
                    end
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg[0] <= cnt_next[0];
            cnt_reg[1] <= cnt_next[1];
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        offset_reg <= offset_next;
        sel_reg    <= sel_next;
        res_reg    <= res_next;
    end

endmodule
`default_nettype wire

/* src/double_buffer_floor_search.sv */
// Floor search over two banks of ascending sample-offset keys.
// Input channel (in_valid/in_ready) carries kind, bank, key and play_position.
// A clear or append transaction completes in the cycle it is accepted and
// produces no result; appends to a full bank are dropped.
// A query transaction splits play_position into a 14-bit offset and a bank bit,
// then binary-searches that bank in the key memory. Each probe issues a read
// in S_CHECK and compares the registered read data in S_CMP; a full bank
// holds 128 keys, and one query is in flight at a time.
// The output channel (out_valid/out_ready) carries entry_index, below_all and
// bank_used from an output register. While a result waits there, the next
// transaction is still accepted; a second query result waits in the search
// unit, and the input stalls until the output register frees up.
// Reset empties both banks; key storage is not cleared and holds garbage
// until written, which is never compared since only filled entries are searched.
`default_nettype none
`include "assert_macros.svh"
module double_buffer_floor_search
    import dbfs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           kind,
    input  wire logic                 bank,
    input  wire logic [KEY_W-1:0]     key,
    input  wire logic [POS_W-1:0]     play_position,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [OUT_IDX_W-1:0]      entry_index,
    output logic                      below_all,
    output logic                      bank_used
);

    logic                idle;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [KEY_W-1:0]    mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [KEY_W-1:0]    mem_rdata;
    logic                res_valid;
    dbfs_result_t        res;
    logic                res_take;
    logic                out_valid_reg, out_valid_next;
    dbfs_result_t        out_reg, out_next;

    assign in_ready = idle;
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    dbfs_key_ram #(
        .DEPTH (2 * TABLE_DEPTH),
        .WIDTH (KEY_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dbfs_search_ctrl u_search_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (in_valid),
        .idle          (idle),
        .kind          (kind),
        .bank          (bank),
        .key           (key),
        .play_position (play_position),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .res_valid     (res_valid),
        .res           (res),
        .res_take      (res_take)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = out_reg.entry_index;
    assign below_all   = out_reg.below_all;
    assign bank_used   = out_reg.bank_used;

    `DBFS_ASSERT(a_below_all_index_zero, !(out_valid && below_all && (entry_index != '0)), "below_all result carries a nonzero index")
    `DBFS_ASSERT_NEXT(a_query_busy, in_valid && in_ready && (kind == KIND_QUERY), !in_ready, "input still ready after a query transaction")
    `DBFS_ASSERT_NEXT(a_update_one_cycle, in_valid && in_ready && (kind != KIND_QUERY), in_ready, "clear or append transaction stalled the input")

endmodule
`default_nettype wire
